FILE: hw/rtl/turtle_path_point_generator_macros.svh
// ---------------------------------------------------------------------------
// Turtle path point generator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TURTLE_PATH_POINT_GENERATOR_MACROS_SVH
`define TURTLE_PATH_POINT_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tpg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tpg assertion failed");

`endif

FILE: hw/rtl/tpg_pkg.sv
// ---------------------------------------------------------------------------
// Turtle path point generator package
// Widths, symbol codes, sine table and shared fixed-point helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpg_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int POS_BITS   = 32;
  localparam int FRAC_BITS  = 16;

  localparam int STEP_BITS  = 16;
  localparam int SYM_BITS   = 8;
  localparam int OUT_BITS   = 32;
  localparam int DELTA_BITS = FRAC_BITS + 2;

  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 2 ** Q_AW;

  localparam logic [SYM_BITS-1:0] SYM_LEFT  = 8'h2B;
  localparam logic [SYM_BITS-1:0] SYM_RIGHT = 8'h2D;

  localparam int CA_SH  = ANGLE_BITS - 8;
  localparam int CA_SH1 = (CA_SH > 0) ? CA_SH - 1 : 0;
  localparam int SC_SHL = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int SC_SHR = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
  localparam int SC_SHR1 = (SC_SHR > 0) ? SC_SHR - 1 : 0;

  localparam logic [15:0] QSIN [0:64] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  typedef logic signed [DELTA_BITS-1:0] delta_t;

  typedef struct packed {
    logic   start;
    logic   draw;
    delta_t dx;
    delta_t dy;
  } cmd_t;

  function automatic logic [7:0] coarse_angle(input logic [ANGLE_BITS-1:0] h);
    logic [ANGLE_BITS:0] sum;
    sum = {1'b0, h} + (ANGLE_BITS+1)'(CA_SH > 0 ? (1 << CA_SH1) : 0);
    coarse_angle = (CA_SH > 0) ? 8'(sum >> CA_SH) : h[7:0];
  endfunction

  function automatic logic [FRAC_BITS:0] scale_mag(input logic [15:0] m);
    logic [31:0] ext;
    logic [31:0] res;
    ext = {16'b0, m};
    if (FRAC_BITS >= 15) begin
      res = ext << SC_SHL;
    end else begin
      res = (ext + (32'd1 << SC_SHR1)) >> SC_SHR;
    end
    scale_mag = res[FRAC_BITS:0];
  endfunction

  function automatic delta_t scaled_sine(input logic [7:0] a8);
    logic [1:0]  quad;
    logic [5:0]  idx;
    logic [6:0]  ridx;
    logic [15:0] mag;
    delta_t      smag;
    quad = a8[7:6];
    idx  = a8[5:0];
    ridx = 7'd64 - {1'b0, idx};
    mag  = quad[0] ? QSIN[ridx] : QSIN[{1'b0, idx}];
    smag = delta_t'({1'b0, scale_mag(mag)});
    scaled_sine = quad[1] ? -smag : smag;
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [POS_BITS-1:0] p);
    logic [63:0] ext;
    ext = 64'(p);
    to_out = ext[OUT_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/tpg_cmd_queue.sv
// ---------------------------------------------------------------------------
// Turtle path point generator command queue
// Small register queue of move commands between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpg_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tpg_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output tpg_pkg::cmd_t  head,
  output logic           empty
);
  import tpg_pkg::*;

  cmd_t            entries_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tpg_front.sv
// ---------------------------------------------------------------------------
// Turtle path point generator front end
// Accepts symbols, keeps the heading and turns draws and start requests into move commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tpg_pkg::STEP_BITS-1:0] cfg_wr_data,
  input  logic                          sym_valid,
  output logic                          sym_ready,
  input  logic [tpg_pkg::SYM_BITS-1:0]  sym,
  input  logic                          start_req,
  output logic                          push,
  output tpg_pkg::cmd_t                 push_data,
  input  logic                          q_full
);
  import tpg_pkg::*;

  logic [STEP_BITS-1:0]  heading_step_r;
  logic [ANGLE_BITS-1:0] heading_r;
  logic [ANGLE_BITS-1:0] heading_nxt;
  logic [ANGLE_BITS-1:0] step_ext;
  logic [39:0]           step_wide;
  logic [7:0]            a8;
  logic                  accept;
  logic                  is_left;
  logic                  is_right;
  logic                  is_turn;

  assign sym_ready = !q_full;
  assign accept    = sym_valid && sym_ready;
  assign is_left   = (sym == SYM_LEFT);
  assign is_right  = (sym == SYM_RIGHT);
  assign is_turn   = is_left || is_right;
  assign step_wide = {24'b0, heading_step_r};
  assign step_ext  = step_wide[ANGLE_BITS-1:0];
  assign a8        = coarse_angle(heading_r);

  assign push            = accept && (!is_turn || start_req);
  assign push_data.start = start_req;
  assign push_data.draw  = !is_turn;
  assign push_data.dx    = scaled_sine(a8 + 8'd64);
  assign push_data.dy    = scaled_sine(a8);

  always_comb begin
    heading_nxt = heading_r;
    if (accept && is_left) begin
      heading_nxt = heading_r + step_ext;
    end else if (accept && is_right) begin
      heading_nxt = heading_r - step_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_step_r <= '0;
      heading_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        heading_step_r <= cfg_wr_data;
      end
      heading_r <= heading_nxt;
    end
  end

endmodule

FILE: hw/rtl/tpg_back.sv
// ---------------------------------------------------------------------------
// Turtle path point generator back end
// Applies move commands to the position and drives the point output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tpg_pkg::cmd_t                head,
  input  logic                         q_empty,
  output logic                         pop,
  output logic                         pt_valid,
  input  logic                         pt_ready,
  output logic [tpg_pkg::OUT_BITS-1:0] pt_x,
  output logic [tpg_pkg::OUT_BITS-1:0] pt_y,
  output logic                         pt_last
);
  import tpg_pkg::*;

  typedef logic signed [POS_BITS-1:0] pos_t;

  pos_t                cur_x_r;
  pos_t                cur_y_r;
  pos_t                new_x;
  pos_t                new_y;
  logic                phase_r;
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_x_r;
  logic [OUT_BITS-1:0] out_y_r;
  logic                out_last_r;
  logic                load;
  logic                emit_old;

  function automatic pos_t sat_add(input pos_t a, input delta_t d);
    logic signed [POS_BITS:0] sum;
    sum = (POS_BITS+1)'(a) + (POS_BITS+1)'(d);
    if (sum[POS_BITS] != sum[POS_BITS-1]) begin
      sat_add = sum[POS_BITS] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
    end else begin
      sat_add = sum[POS_BITS-1:0];
    end
  endfunction

  assign new_x    = sat_add(cur_x_r, head.dx);
  assign new_y    = sat_add(cur_y_r, head.dy);
  assign load     = !q_empty && (!out_valid_r || pt_ready);
  assign emit_old = head.start && !phase_r;
  assign pop      = load && !(emit_old && head.draw);

  assign pt_valid = out_valid_r;
  assign pt_x     = out_x_r;
  assign pt_y     = out_y_r;
  assign pt_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        if (emit_old) begin
          out_x_r    <= to_out(cur_x_r);
          out_y_r    <= to_out(cur_y_r);
          out_last_r <= !head.draw;
          phase_r    <= head.draw;
        end else begin
          cur_x_r    <= new_x;
          cur_y_r    <= new_y;
          out_x_r    <= to_out(new_x);
          out_y_r    <= to_out(new_y);
          out_last_r <= 1'b1;
          phase_r    <= 1'b0;
        end
      end else if (pt_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/turtle_path_point_generator.sv
// ---------------------------------------------------------------------------
// Turtle path point generator
// Interprets L-system symbols as turtle moves and streams the drawn points.
// ---------------------------------------------------------------------------
// The input channel takes one ASCII symbol per item in in_tdata, with the
// start request in in_tuser. A plus or minus symbol turns the heading by the
// step held in the configuration register, written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Any other symbol moves one unit along
// the heading and emits the new point. A start request first emits the
// current point. Each output item carries x and y in out_tdata, and out_tlast
// marks the final point caused by an input item. An item is accepted every
// cycle while the four-entry command queue has room. A drawn point is
// registered in the command queue and then in the point output register.
// When the receiver stalls, the queue fills and in_tready falls only once it
// is full. Reset clears the position, the heading and the turn step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module turtle_path_point_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol
  input  logic        in_tuser,   // start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // pos_x, pos_y
  output logic        out_tlast
);
  import tpg_pkg::*;

  cmd_t                push_data;
  cmd_t                head;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  logic [OUT_BITS-1:0] pt_x;
  logic [OUT_BITS-1:0] pt_y;

  tpg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sym_valid   (in_tvalid),
    .sym_ready   (in_tready),
    .sym         (in_tdata),
    .start_req   (in_tuser),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  tpg_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  tpg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .pt_valid (out_tvalid),
    .pt_ready (out_tready),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_last  (out_tlast)
  );

  assign out_tdata = {pt_y, pt_x};

endmodule

FILE: hw/rtl/tpg_checker.sv
// ---------------------------------------------------------------------------
// Turtle path point generator port checker
// Watches the top-level ports and flags illegal behavior over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "turtle_path_point_generator_macros.svh"

module tpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  `TPG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  `TPG_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_tvalid && out_tready && !out_tlast,
    out_tvalid)

  `TPG_ASSERT_NOW(a_idle_after_reset, clk, rst_n, $past(!rst_n), !out_tvalid)

  `TPG_ASSERT_NOW(a_ready_after_reset, clk, rst_n, $past(!rst_n), in_tready)

endmodule

bind turtle_path_point_generator tpg_checker u_tpg_checker (.*);

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// Turtle path point generator testbench
// Drives symbol items with random gaps and start requests. The testbench
// keeps its own turtle (heading, position and turn step) to predict every
// point, and compares the points that come out in order. Covered are turn
// steps from zero to full range, random receiver stalls and one long hold,
// and straight diagonal runs sent back to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] sym;
    logic       start;
  } symbol_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } turtle_point_t;

  localparam int SINE_Q [0:64] = '{
    0, 804, 1608, 2411, 3212, 4011, 4808, 5602,
    6393, 7180, 7962, 8740, 9512, 10279, 11039, 11793,
    12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
    18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
    23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
    27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
    30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
    32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
    32768
  };

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;

  symbol_item_t  pending_symbols [$];
  turtle_point_t expected_points [$];

  logic [15:0]        turtle_heading = '0;
  logic signed [31:0] turtle_x = '0;
  logic signed [31:0] turtle_y = '0;
  logic [15:0]        turn_step = '0;

  bit idle_on = 1'b1;
  int mismatches = 0;
  int points_seen = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int send_roll;
  int stall_roll;

  turtle_path_point_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] unit_sine(input logic [7:0] angle);
    int mag;
    if (angle[6]) begin
      mag = SINE_Q[64 - int'(angle[5:0])];
    end else begin
      mag = SINE_Q[int'(angle[5:0])];
    end
    mag = mag * 2;
    return angle[7] ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > POS_MAX) return POS_MAX[31:0];
    if (s < POS_MIN) return POS_MIN[31:0];
    return s[31:0];
  endfunction

  function automatic void advance_turtle(input logic [7:0] sym, input logic start);
    logic [16:0] rounded;
    logic [7:0]  dir;
    if (sym == tpg_pkg::SYM_LEFT || sym == tpg_pkg::SYM_RIGHT) begin
      if (start) expected_points.push_back('{turtle_x, turtle_y, 1'b1});
      if (sym == tpg_pkg::SYM_LEFT) begin
        turtle_heading = turtle_heading + turn_step;
      end else begin
        turtle_heading = turtle_heading - turn_step;
      end
    end else begin
      if (start) expected_points.push_back('{turtle_x, turtle_y, 1'b0});
      rounded = {1'b0, turtle_heading} + 17'd128;
      dir = rounded[15:8];
      turtle_x = clamp_add(turtle_x, unit_sine(dir + 8'd64));
      turtle_y = clamp_add(turtle_y, unit_sine(dir));
      expected_points.push_back('{turtle_x, turtle_y, 1'b1});
    end
  endfunction

  function automatic int pick_gap(input int roll);
    if (!idle_on || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return tpg_pkg::SYM_LEFT;
    if (r < 45) return tpg_pkg::SYM_RIGHT;
    if (r < 70) return 8'h46;
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) advance_turtle(in_tdata, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_symbols.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_symbols[0].sym;
          in_tuser <= pending_symbols[0].start;
          void'(pending_symbols.pop_front());
          send_roll = $urandom_range(0, 99);
          send_gap <= pick_gap(send_roll);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!held_once && points_seen >= 300) begin
      held_once <= 1'b1;
      hold_left <= 120;
      out_tready <= 1'b0;
    end else if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    turtle_point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      points_seen <= points_seen + 1;
      if (expected_points.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("Unexpected point x=%0d y=%0d last=%0b", $signed(out_tdata[31:0]),
                   $signed(out_tdata[63:32]), out_tlast);
        end
      end else begin
        want = expected_points.pop_front();
        if (out_tdata[31:0] !== want.x || out_tdata[63:32] !== want.y ||
            out_tlast !== want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("Point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.x, want.y, want.last, $signed(out_tdata[31:0]),
                     $signed(out_tdata[63:32]), out_tlast);
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_symbols.size() > 0 || in_tvalid || expected_points.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_turn_step(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    turn_step = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_symbol(input logic [7:0] sym, input logic start);
    pending_symbols.push_back('{sym, start});
  endtask

  initial begin
    logic [15:0] steps [8];
    int k;
    steps = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0080, 16'h8000, 16'h2AAB,
              16'h0000, 16'h0000};
    steps[6] = 16'($urandom_range(0, 65535));
    steps[7] = 16'($urandom_range(0, 65535));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_turn_step(16'h4000);

    queue_symbol(8'h46, 1'b0);
    queue_symbol(tpg_pkg::SYM_LEFT, 1'b1);
    queue_symbol(8'h46, 1'b1);
    queue_symbol(8'hFF, 1'b0);
    queue_symbol(tpg_pkg::SYM_RIGHT, 1'b0);
    queue_symbol(tpg_pkg::SYM_RIGHT, 1'b1);
    queue_symbol(8'h00, 1'b1);
    queue_symbol(8'h2A, 1'b0);
    queue_symbol(8'h2C, 1'b1);
    queue_symbol(tpg_pkg::SYM_LEFT, 1'b0);
    queue_symbol(tpg_pkg::SYM_LEFT, 1'b0);
    queue_symbol(8'hFF, 1'b1);
    queue_symbol(tpg_pkg::SYM_RIGHT, 1'b1);
    queue_symbol(8'h80, 1'b0);
    queue_symbol(8'h7F, 1'b1);
    queue_symbol(tpg_pkg::SYM_LEFT, 1'b1);
    queue_symbol(8'h00, 1'b0);
    queue_symbol(8'h55, 1'b0);
    queue_symbol(8'hAA, 1'b1);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      idle_on = (p % 3 != 2);
      write_turn_step(steps[p]);
      for (int i = 0; i < 220; i++) begin
        queue_symbol(random_symbol(), $urandom_range(0, 3) == 0);
      end
      wait_idle();
    end

    // Aim the turtle along the diagonal, then run it straight out and
    // back again with no gaps.
    idle_on = 1'b0;
    write_turn_step(16'h2000 - turtle_heading);
    queue_symbol(tpg_pkg::SYM_LEFT, 1'b0);
    for (k = 0; k < 20; k++) queue_symbol(8'h46, $urandom_range(0, 19) == 0);
    wait_idle();
    write_turn_step(16'h8000);
    queue_symbol(tpg_pkg::SYM_LEFT, 1'b1);
    for (k = 0; k < 20; k++) queue_symbol(8'h46, $urandom_range(0, 19) == 0);
    wait_idle();
    idle_on = 1'b1;
    write_turn_step(16'($urandom_range(0, 65535)));
    for (k = 0; k < 60; k++) queue_symbol(random_symbol(), $urandom_range(0, 3) == 0);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
